>>> hdl/ma3_pkg.sv
// ma3_pkg: types and constants shared by the three-sample moving average
// no dependencies; imported by the channel interfaces and all ma3 modules
`default_nettype none

package ma3_pkg;

  // sample and average width
  localparam int unsigned SampleBits = 16;
  // entries held in the window
  localparam int unsigned WindowLen  = 3;
  // fill level saturates here
  localparam int unsigned FillMax    = 4;
  localparam int unsigned FillBits   = $clog2(FillMax + 1);
  localparam int unsigned SlotBits   = $clog2(WindowLen);

  // dividend of the divide by three: a three-sample sum plus the rounding one
  localparam int unsigned DivBits    = SampleBits + 2;
  // reciprocal multiply: x / 3 == (x * ceil(2^k / 3)) >> k, exact for x < 2^(k-2)
  localparam int unsigned Div3Shift  = DivBits + 2;
  localparam int unsigned ProdBits   = DivBits + Div3Shift;
  localparam logic [Div3Shift-1:0] Div3Recip =
    Div3Shift'(((64'd1 << Div3Shift) + 64'd2) / 64'd3);

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [FillBits-1:0]   fill_t;
  typedef logic [SlotBits-1:0]   slot_t;
  typedef logic [DivBits-1:0]    dividend_t;

  // operation codes of the func field
  typedef enum logic {
    FUNC_ADD   = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_e;

  // fill levels with a meaning of their own
  localparam fill_t FillEmpty = fill_t'(0);
  localparam fill_t FillOne   = fill_t'(1);
  localparam fill_t FillTwo   = fill_t'(2);
  localparam fill_t FillFull  = fill_t'(WindowLen);
  localparam fill_t FillSat   = fill_t'(FillMax);
  localparam slot_t SlotLast  = slot_t'(WindowLen - 1);

  // one item handed to the window datapath
  typedef struct packed {
    logic    fire;
    func_e   func;
    sample_t sample;
  } step_t;

  // result of one item
  typedef struct packed {
    sample_t average;
    logic    window_full;
  } result_t;

endpackage

`default_nettype wire

>>> hdl/ma3_in_if.sv
// ma3_in_if: input channel of the moving average (valid/ready, func, sample)
// depends on ma3_pkg
`default_nettype none

interface ma3_in_if;
  import ma3_pkg::*;

  logic    valid;
  logic    ready;
  logic    func;
  sample_t sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);
endinterface

`default_nettype wire

>>> hdl/ma3_out_if.sv
// ma3_out_if: result channel of the moving average (valid/ready, average, window_full)
// depends on ma3_pkg
`default_nettype none

interface ma3_out_if;
  import ma3_pkg::*;

  logic    valid;
  logic    ready;
  sample_t average;
  logic    window_full;

  modport source (output valid, output average, output window_full, input ready);
  modport sink   (input valid, input average, input window_full, output ready);
endinterface

`default_nettype wire

>>> hdl/moving_average_window3.sv
// three-sample rounded moving average, top level with input and result registers
// depends on ma3_pkg, ma3_in_if, ma3_out_if, ma3_window
// path: a transferred sample is held in the input register, then in the result register
// throughput: one item per cycle unless the result side stalls, with the single divide-by-three
// multiply between the input register and the result register
// reset: clears fill level, write slot, running average and both valid bits;
// ring entries are left as they are and are only read after being written
`default_nettype none

module moving_average_window3 (
  input  wire     clk_i,
  input  wire     rst_ni,
  ma3_in_if.sink  in_i,
  ma3_out_if.source out_o
);
  import ma3_pkg::*;

  logic    in_valid_q;
  func_e   func_q;
  sample_t sample_q;
  logic    out_valid_q;
  result_t res_q;

  logic    advance;
  logic    in_xfer;
  step_t   step;
  result_t res;

  // the result register frees up when empty or when taken
  assign advance  = !out_valid_q || out_o.ready;
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer  = in_i.valid && in_i.ready;

  assign step.fire   = in_valid_q && advance;
  assign step.func   = func_q;
  assign step.sample = sample_q;

  ma3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .result_o (res)
  );

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      func_q   <= func_e'(in_i.func);
      sample_q <= in_i.sample;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (step.fire) begin
      res_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.average     = res_q.average;
  assign out_o.window_full = res_q.window_full;

  // a held item is not dropped while the result side stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input item lost under stall");

  // an item moving on always lands in the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.fire |=> out_valid_q)
    else $error("item moved on without a result");

  // a stalled result keeps its value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(res_q)))
    else $error("stalled result changed");

endmodule

`default_nettype wire

>>> hdl/ma3_div3.sv
// ma3_div3: exact unsigned divide by three through a reciprocal multiply
// depends on ma3_pkg
`default_nettype none

module ma3_div3 (
  input  wire ma3_pkg::dividend_t dividend_i,
  output ma3_pkg::sample_t        quotient_o
);
  import ma3_pkg::*;

  logic [ProdBits-1:0] prod;

  // one multiply, then keep the bits above the fixed-point shift
  assign prod       = ProdBits'(dividend_i) * ProdBits'(Div3Recip);
  assign quotient_o = prod[Div3Shift +: SampleBits];

endmodule

`default_nettype wire

>>> hdl/ma3_window.sv
// ma3_window: sample ring, fill level, write slot and running average,
// with the per-item result logic; depends on ma3_pkg and ma3_div3
`default_nettype none

module ma3_window (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  ma3_pkg::step_t   step_i,
  output ma3_pkg::result_t result_o
);
  import ma3_pkg::*;

  sample_t   ring_q [WindowLen];
  slot_t     slot_q, slot_d;
  fill_t     fill_q, fill_d;
  sample_t   avg_q, avg_d;

  fill_t     fill_inc;
  sample_t   oldest;
  logic      up;
  logic [SampleBits:0] diff;
  logic [SampleBits:0] pair_sum;
  dividend_t dividend;
  sample_t   quot;
  sample_t   avg_next;
  sample_t   partial;
  logic      is_clear;

  assign is_clear = (step_i.func == FUNC_CLEAR);

  // saturating fill count for an add
  assign fill_inc = (fill_q == FillSat) ? FillSat : fill_t'(fill_q + fill_t'(1));

  // oldest sample, the one about to be overwritten
  always_comb begin
    unique case (slot_q)
      slot_t'(0): oldest = ring_q[0];
      slot_t'(1): oldest = ring_q[1];
      default:    oldest = ring_q[SlotLast];
    endcase
  end

  // magnitude of new minus oldest; the rounding one is added in the dividend
  assign up   = (step_i.sample >= oldest);
  assign diff = up ? ((SampleBits+1)'(step_i.sample) - (SampleBits+1)'(oldest))
                   : ((SampleBits+1)'(oldest) - (SampleBits+1)'(step_i.sample));

  // shared divide: full three-sample sum on the third add, difference afterwards
  always_comb begin
    if (fill_inc == FillFull) begin
      dividend = DivBits'(ring_q[0]) + DivBits'(ring_q[1]) + DivBits'(step_i.sample)
               + DivBits'(1);
    end else begin
      dividend = DivBits'(diff) + DivBits'(1);
    end
  end

  ma3_div3 u_div3 (
    .dividend_i (dividend),
    .quotient_o (quot)
  );

  // running average after this add, wrapping
  always_comb begin
    if (fill_inc == FillFull) begin
      avg_next = quot;
    end else if (up) begin
      avg_next = avg_q + quot;
    end else begin
      avg_next = avg_q - quot;
    end
  end

  // rounded mean while the window is not yet full
  assign pair_sum = (SampleBits+1)'(ring_q[0]) + (SampleBits+1)'(step_i.sample)
                  + (SampleBits+1)'(1);
  always_comb begin
    if (fill_inc == FillOne) begin
      partial = step_i.sample;
    end else begin
      partial = pair_sum[SampleBits:1];
    end
  end

  // result of this item
  always_comb begin
    if (is_clear) begin
      result_o.average     = '0;
      result_o.window_full = 1'b0;
    end else if (fill_inc < FillFull) begin
      result_o.average     = partial;
      result_o.window_full = 1'b0;
    end else begin
      result_o.average     = avg_next;
      result_o.window_full = 1'b1;
    end
  end

  // next control state
  always_comb begin
    slot_d = slot_q;
    fill_d = fill_q;
    avg_d  = avg_q;
    if (step_i.fire) begin
      if (is_clear) begin
        slot_d = '0;
        fill_d = FillEmpty;
        avg_d  = '0;
      end else begin
        slot_d = (slot_q == SlotLast) ? slot_t'(0) : slot_t'(slot_q + slot_t'(1));
        fill_d = fill_inc;
        if (fill_inc >= FillFull) begin
          avg_d = avg_next;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= FillEmpty;
      avg_q  <= '0;
    end else begin
      slot_q <= slot_d;
      fill_q <= fill_d;
      avg_q  <= avg_d;
    end
  end

  // ring write at the current slot
  for (genvar i = 0; i < WindowLen; i++) begin : g_ring
    always_ff @(posedge clk_i) begin
      if (step_i.fire && !is_clear && (slot_q == slot_t'(i))) begin
        ring_q[i] <= step_i.sample;
      end
    end
  end

  // fill level never passes saturation
  assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= FillSat)
    else $error("fill level beyond saturation");

  // write slot stays inside the ring
  assert property (@(posedge clk_i) disable iff (!rst_ni) slot_q <= SlotLast)
    else $error("write slot outside the ring");

  // while filling, the write slot tracks the fill level
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q < FillFull) |-> (fill_q == fill_t'(slot_q)))
    else $error("write slot out of step with fill level");

  // a clear empties the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i.fire && is_clear) |=> (fill_q == FillEmpty && slot_q == '0 && avg_q == '0))
    else $error("clear did not empty the window");

endmodule

`default_nettype wire
